// ===== rtl/glg_pkg.sv =====
package glg_pkg;

    localparam int IDX_W      = 10;
    localparam int COL_W      = 24;
    localparam int LEVEL_W    = 8;
    localparam int DIVIDEND_W = 16;
    localparam int DIVISOR_W  = 10;
    localparam int STEP_W     = 17;
    localparam int SUM_W      = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_RECT_X       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RECT_Y       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RECT_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RECT_HEIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_COLOUR = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_COLOUR  = 3'd6;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    function automatic logic [LEVEL_W-1:0] chan_byte(input logic [COL_W-1:0] colour,
                                                     input logic [1:0] ch);
        logic [LEVEL_W-1:0] res;
        case (ch)
            CH_RED:   res = colour[23:16];
            CH_GREEN: res = colour[15:8];
            default:  res = colour[7:0];
        endcase
        return res;
    endfunction

endpackage

// ===== rtl/glg_divider.sv =====
module glg_divider
    import glg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  div_ctrl_t             ctrl,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output div_status_t           status,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] num_reg, num_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  divisor_reg, divisor_next;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    assign trial = {rem_reg, num_reg[DIVIDEND_W-1]};
    assign fits  = trial >= {1'b0, divisor_reg};

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        num_next     = num_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;
        if (ctrl.start)
        begin
            busy_next    = 1'b1;
            cnt_next     = '0;
            rem_next     = '0;
            num_next     = dividend;
            quo_next     = '0;
            divisor_next = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DIVISOR_W'(trial - {1'b0, divisor_reg}) : trial[DIVISOR_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            num_next = {num_reg[DIVIDEND_W-2:0], 1'b0};
            cnt_next = CNT_W'(cnt_reg + 1'b1);
            if (cnt_reg == CNT_W'(DIVIDEND_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        num_reg     <= num_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

// ===== rtl/gradient_line_generator_core.sv =====
// Restart: each channel step runs start, 16 shared serial divider steps, then capture, for
// red, green and blue in turn before the result is loaded. An advance steps one channel a
// cycle, then loads; with no active fill or at the last line it loads a zeroed, invalid result.
// Transactions are handled one at a time; the next is accepted the cycle after the result
// is loaded, and loading waits while out_stall holds a pending result. Reset (rst_n, async,
// active low) clears control state and registers to defaults; width and height reset to 1.
module gradient_line_generator_core
    import glg_pkg::*;
#(
    parameter int MAX_DIM = 512
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  restart,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  line_valid,
    output logic [9:0]            line_x,
    output logic [9:0]            line_y,
    output logic [9:0]            line_width,
    output logic [9:0]            line_height,
    output logic [COL_W-1:0]      line_colour,
    output logic                  last_line
);

    typedef enum logic [4:0] {
        ST_IDLE      = 5'b00001,
        ST_DIV_START = 5'b00010,
        ST_DIV_WAIT  = 5'b00100,
        ST_ADVANCE   = 5'b01000,
        ST_OUTPUT    = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [8:0]       rect_x_reg, rect_y_reg;
    logic [9:0]       rect_width_reg, rect_height_reg;
    logic             direction_reg;
    logic [COL_W-1:0] first_colour_reg, last_colour_reg;

    logic [IDX_W-1:0]   line_index_reg, line_index_next;
    logic               fill_active_reg, fill_active_next;
    logic               zero_reg, zero_next;
    logic [1:0]         ch_reg, ch_next;
    logic               sign_reg, sign_next;
    logic [STEP_W-1:0]  step_reg  [3];
    logic [STEP_W-1:0]  acc_reg   [3];
    logic [LEVEL_W-1:0] level_reg [3];

    logic             out_valid_reg, out_valid_next;
    logic             line_valid_reg;
    logic [9:0]       line_x_reg, line_y_reg, line_width_reg, line_height_reg;
    logic [COL_W-1:0] line_colour_reg;
    logic             last_line_reg;
    logic             load_out;

    div_ctrl_t             div_ctrl;
    div_status_t           div_status;
    logic [DIVIDEND_W-1:0] div_quotient;

    function automatic logic [9:0] clamp_dim(input logic [9:0] v);
        logic [9:0] res;
        if (v == '0)
            res = 10'd1;
        else if (32'(v) > MAX_DIM)
            res = 10'(MAX_DIM);
        else
            res = v;
        return res;
    endfunction

    logic [9:0]         width_c, height_c, count_c;
    logic               at_end;
    logic [LEVEL_W-1:0] first_byte, last_byte;
    logic [8:0]         diff;
    logic [LEVEL_W-1:0] diff_mag;
    logic [STEP_W-1:0]  step_new;

    logic [SUM_W-1:0]   sum;
    logic               sum_neg;
    logic [SUM_W-1:0]   sum_mag;
    logic [LEVEL_W-1:0] whole;
    logic [LEVEL_W-1:0] frac;
    logic [STEP_W-1:0]  acc_new;
    logic [LEVEL_W-1:0] level_new;
    logic               adv_step;
    logic               div_capture;

    assign width_c  = clamp_dim(rect_width_reg);
    assign height_c = clamp_dim(rect_height_reg);
    assign count_c  = direction_reg ? height_c : width_c;
    assign at_end   = ({1'b0, line_index_reg} + 11'd1) >= {1'b0, count_c};

    assign first_byte = chan_byte(first_colour_reg, ch_reg);
    assign last_byte  = chan_byte(last_colour_reg, ch_reg);
    assign diff       = {1'b0, last_byte} - {1'b0, first_byte};
    assign diff_mag   = diff[8] ? LEVEL_W'(-diff) : diff[7:0];
    assign step_new   = sign_reg ? STEP_W'(-{1'b0, div_quotient}) : {1'b0, div_quotient};

    assign sum     = {acc_reg[ch_reg][STEP_W-1], acc_reg[ch_reg]}
                   + {step_reg[ch_reg][STEP_W-1], step_reg[ch_reg]};
    assign sum_neg = sum[SUM_W-1];
    assign sum_mag = sum_neg ? SUM_W'(-sum) : sum;
    assign whole   = sum_mag[15:8];
    assign frac    = sum_mag[7:0];
    assign acc_new = sum_neg ? STEP_W'(-{9'd0, frac}) : {9'd0, frac};
    assign level_new = sum_neg ? LEVEL_W'(level_reg[ch_reg] - whole)
                               : LEVEL_W'(level_reg[ch_reg] + whole);

    assign div_ctrl.start = (state_reg == ST_DIV_START);
    assign div_capture    = (state_reg == ST_DIV_WAIT) && div_status.done;
    assign adv_step       = (state_reg == ST_ADVANCE);
    assign load_out       = (state_reg == ST_OUTPUT) && (!out_valid_reg || !out_stall);

    glg_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend ({diff_mag, 8'd0}),
        .divisor  (count_c),
        .status   (div_status),
        .quotient (div_quotient)
    );

    always_comb
    begin
        state_next       = state_reg;
        line_index_next  = line_index_reg;
        fill_active_next = fill_active_reg;
        zero_next        = zero_reg;
        ch_next          = ch_reg;
        sign_next        = sign_reg;
        out_valid_next   = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ch_next   = CH_RED;
                    zero_next = 1'b0;
                    if (restart)
                        state_next = ST_DIV_START;
                    else if (!fill_active_reg || at_end)
                    begin
                        fill_active_next = 1'b0;
                        zero_next        = 1'b1;
                        state_next       = ST_OUTPUT;
                    end
                    else
                        state_next = ST_ADVANCE;
                end
            end
            ST_DIV_START:
            begin
                sign_next  = diff[8];
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_status.done)
                begin
                    if (ch_reg == CH_BLUE)
                    begin
                        line_index_next  = '0;
                        fill_active_next = (count_c > 10'd1);
                        state_next       = ST_OUTPUT;
                    end
                    else
                    begin
                        ch_next    = ch_reg + 2'd1;
                        state_next = ST_DIV_START;
                    end
                end
            end
            ST_ADVANCE:
            begin
                if (ch_reg == CH_BLUE)
                begin
                    line_index_next  = line_index_reg + 1'b1;
                    fill_active_next = !(({1'b0, line_index_reg} + 11'd2) >= {1'b0, count_c});
                    state_next       = ST_OUTPUT;
                end
                else
                    ch_next = ch_reg + 2'd1;
            end
            ST_OUTPUT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            line_index_reg   <= '0;
            fill_active_reg  <= 1'b0;
            zero_reg         <= 1'b0;
            ch_reg           <= CH_RED;
            sign_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
            rect_x_reg       <= '0;
            rect_y_reg       <= '0;
            rect_width_reg   <= 10'd1;
            rect_height_reg  <= 10'd1;
            direction_reg    <= 1'b0;
            first_colour_reg <= '0;
            last_colour_reg  <= '0;
            for (int i = 0; i < 3; i++)
            begin
                step_reg[i]  <= '0;
                acc_reg[i]   <= '0;
                level_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg       <= state_next;
            line_index_reg  <= line_index_next;
            fill_active_reg <= fill_active_next;
            zero_reg        <= zero_next;
            ch_reg          <= ch_next;
            sign_reg        <= sign_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_RECT_X:       rect_x_reg       <= cfg_data[8:0];
                    REG_RECT_Y:       rect_y_reg       <= cfg_data[8:0];
                    REG_RECT_WIDTH:   rect_width_reg   <= cfg_data[9:0];
                    REG_RECT_HEIGHT:  rect_height_reg  <= cfg_data[9:0];
                    REG_DIRECTION:    direction_reg    <= cfg_data[0];
                    REG_FIRST_COLOUR: first_colour_reg <= cfg_data;
                    REG_LAST_COLOUR:  last_colour_reg  <= cfg_data;
                    default:          ;
                endcase
            end
            if (div_capture)
            begin
                step_reg[ch_reg]  <= step_new;
                acc_reg[ch_reg]   <= '0;
                level_reg[ch_reg] <= first_byte;
            end
            else if (adv_step)
            begin
                acc_reg[ch_reg]   <= acc_new;
                level_reg[ch_reg] <= level_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            if (zero_reg)
            begin
                line_valid_reg  <= 1'b0;
                line_x_reg      <= '0;
                line_y_reg      <= '0;
                line_width_reg  <= '0;
                line_height_reg <= '0;
                line_colour_reg <= '0;
                last_line_reg   <= 1'b0;
            end
            else
            begin
                line_valid_reg  <= 1'b1;
                line_x_reg      <= {1'b0, rect_x_reg} + (direction_reg ? '0 : line_index_reg);
                line_y_reg      <= {1'b0, rect_y_reg} + (direction_reg ? line_index_reg : '0);
                line_width_reg  <= direction_reg ? width_c : 10'd1;
                line_height_reg <= direction_reg ? 10'd1 : height_c;
                line_colour_reg <= {level_reg[0], level_reg[1], level_reg[2]};
                last_line_reg   <= at_end;
            end
        end
    end

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign line_valid  = line_valid_reg;
    assign line_x      = line_x_reg;
    assign line_y      = line_y_reg;
    assign line_width  = line_width_reg;
    assign line_height = line_height_reg;
    assign line_colour = line_colour_reg;
    assign last_line   = last_line_reg;

endmodule
